/* hdl/mwf_pkg.sv */
// shared types and codes of the maze wall follower
package mwf_pkg;

  localparam int MAZE_SIZE_DEF = 16;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_STEP    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] HEAD_EAST  = 2'd0;
  localparam logic [1:0] HEAD_SOUTH = 2'd1;
  localparam logic [1:0] HEAD_WEST  = 2'd2;
  localparam logic [1:0] HEAD_NORTH = 2'd3;

  localparam logic [1:0] STAT_MOVED  = 2'd0;
  localparam logic [1:0] STAT_EXIT   = 2'd1;
  localparam logic [1:0] STAT_NOEXIT = 2'd2;
  localparam logic [1:0] STAT_DONE   = 2'd3;

  localparam logic [1:0] CFG_START_ROW     = 2'd0;
  localparam logic [1:0] CFG_START_COL     = 2'd1;
  localparam logic [1:0] CFG_START_HEADING = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } state_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] heading;
    logic [3:0] pos_col;
    logic [3:0] pos_row;
  } result_t;

endpackage

/* hdl/mwf_maze_ram.sv */
// wall bit store with registered read and clearing pass after reset
module mwf_maze_ram #(
  parameter int MAZE_SIZE = mwf_pkg::MAZE_SIZE_DEF,
  parameter int AW = $clog2(MAZE_SIZE * MAZE_SIZE)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata,
  output logic          busy
);
  import mwf_pkg::*;

  localparam int DEPTH = MAZE_SIZE * MAZE_SIZE;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic          mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic          mem_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        busy <= 1'b0;
      end
    end
  end

  assign mem_we   = busy | we;
  assign mem_addr = busy ? clr_addr : waddr;
  assign mem_data = busy ? 1'b0 : wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/mwf_out_fifo.sv */
// two-entry result queue in front of the output stream
module mwf_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mwf_pkg::result_t push_data,
  output logic             full,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output mwf_pkg::result_t head
);
  import mwf_pkg::*;

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop           = m_axis_tvalid & m_axis_tready;
  assign m_axis_tvalid = (count != 2'd0);
  assign full          = (count == 2'd2);
  assign head          = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      priority case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* hdl/mwf_walker.sv */
// walker state, start registers and neighbour probe sequencer
module mwf_walker #(
  parameter int MAZE_SIZE = mwf_pkg::MAZE_SIZE_DEF,
  parameter int IW = $clog2(MAZE_SIZE),
  parameter int AW = $clog2(MAZE_SIZE * MAZE_SIZE)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [3:0]       cfg_data,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [1:0]       opcode,
  input  logic [3:0]       cell_row,
  input  logic [3:0]       cell_col,
  input  logic             cell_wall,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic             ram_wdata,
  output logic [AW-1:0]    ram_raddr,
  input  logic             ram_rdata,
  input  logic             ram_busy,
  input  logic             fifo_full,
  output logic             push,
  output mwf_pkg::result_t push_data
);
  import mwf_pkg::*;

  localparam int CW = (IW + 1 > 4) ? IW + 1 : 4;
  localparam logic [IW-1:0] LAST = IW'(MAZE_SIZE - 1);
  localparam logic [CW-1:0] LAST_EXT = CW'(MAZE_SIZE - 1);
  localparam logic [CW-1:0] SIZE_EXT = CW'(MAZE_SIZE);

  typedef struct packed {
    logic [IW-1:0] row;
    logic [IW-1:0] col;
    logic [1:0]    head;
    logic          oob;
  } cand_t;

  function automatic logic [1:0] try_head(input logic [1:0] h, input logic [1:0] k);
    logic [1:0] t;
    unique case (k)
      2'd0:    t = 2'(h + 2'd1);
      2'd1:    t = h;
      default: t = 2'(h + 2'd3);
    endcase
    return t;
  endfunction

  function automatic cand_t neighbour(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                      input logic [1:0] h);
    cand_t n;
    n.row  = r;
    n.col  = c;
    n.head = h;
    n.oob  = 1'b0;
    unique case (h)
      HEAD_EAST: begin
        n.col = c + 1'b1;
        n.oob = (c == LAST);
      end
      HEAD_SOUTH: begin
        n.row = r + 1'b1;
        n.oob = (r == LAST);
      end
      HEAD_WEST: begin
        n.col = c - 1'b1;
        n.oob = (c == '0);
      end
      default: begin
        n.row = r - 1'b1;
        n.oob = (r == '0);
      end
    endcase
    return n;
  endfunction

  state_t        state, state_next;
  logic [1:0]    try_k, try_k_next;
  logic [IW-1:0] walker_row, walker_row_next;
  logic [IW-1:0] walker_col, walker_col_next;
  logic [1:0]    walker_heading, walker_heading_next;
  logic [3:0]    start_row, start_col;
  logic [1:0]    start_heading;
  cand_t         cand, cand_next, issue_cand;
  logic [1:0]    issue_k;
  logic          accept;
  logic          wall;
  logic [1:0]    status;
  logic [CW-1:0] cell_row_ext, cell_col_ext;
  logic [CW-1:0] start_row_ext, start_col_ext;
  logic [CW-1:0] out_row_ext, out_col_ext;
  logic [IW-1:0] clamp_row, clamp_col;

  assign s_axis_tready = (state == S_IDLE) && !ram_busy && !fifo_full;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign wall          = cand.oob | ram_rdata;

  assign cell_row_ext  = CW'(cell_row);
  assign cell_col_ext  = CW'(cell_col);
  assign start_row_ext = CW'(start_row);
  assign start_col_ext = CW'(start_col);
  assign clamp_row = (start_row_ext > LAST_EXT) ? LAST : start_row_ext[IW-1:0];
  assign clamp_col = (start_col_ext > LAST_EXT) ? LAST : start_col_ext[IW-1:0];

  assign issue_k    = (state == S_PROBE) ? 2'(try_k + 2'd1) : 2'd0;
  assign issue_cand = neighbour(walker_row, walker_col, try_head(walker_heading, issue_k));
  assign ram_raddr  = issue_cand.oob ? '0
                    : AW'(AW'(issue_cand.row) * AW'(MAZE_SIZE) + AW'(issue_cand.col));

  assign ram_waddr = AW'(AW'(cell_row_ext[IW-1:0]) * AW'(MAZE_SIZE)
                   + AW'(cell_col_ext[IW-1:0]));
  assign ram_wdata = cell_wall;

  assign out_row_ext       = CW'(walker_row_next);
  assign out_col_ext       = CW'(walker_col_next);
  assign push_data.pos_row = out_row_ext[3:0];
  assign push_data.pos_col = out_col_ext[3:0];
  assign push_data.heading = walker_heading_next;
  assign push_data.status  = status;

  always_comb begin
    state_next          = state;
    try_k_next          = try_k;
    cand_next           = cand;
    walker_row_next     = walker_row;
    walker_col_next     = walker_col;
    walker_heading_next = walker_heading;
    ram_we              = 1'b0;
    push                = 1'b0;
    status              = STAT_DONE;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode)
            OP_LOAD: begin
              ram_we = (cell_row_ext < SIZE_EXT) && (cell_col_ext < SIZE_EXT);
              push   = 1'b1;
            end
            OP_STEP: begin
              if (walker_col == LAST || walker_row == LAST || walker_row == '0) begin
                push   = 1'b1;
                status = STAT_EXIT;
              end else if (walker_col == '0 && walker_heading == HEAD_WEST) begin
                push   = 1'b1;
                status = STAT_NOEXIT;
              end else begin
                cand_next  = issue_cand;
                try_k_next = 2'd0;
                state_next = S_PROBE;
              end
            end
            OP_RESTART: begin
              walker_row_next     = clamp_row;
              walker_col_next     = clamp_col;
              walker_heading_next = start_heading;
              push                = 1'b1;
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end
      S_PROBE: begin
        if (!wall) begin
          walker_row_next     = cand.row;
          walker_col_next     = cand.col;
          walker_heading_next = cand.head;
          push                = 1'b1;
          status              = STAT_MOVED;
          state_next          = S_IDLE;
        end else if (try_k == 2'd2) begin
          walker_heading_next = 2'(walker_heading + 2'd2);
          push                = 1'b1;
          status              = STAT_MOVED;
          state_next          = S_IDLE;
        end else begin
          cand_next  = issue_cand;
          try_k_next = issue_k;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      try_k          <= 2'd0;
      walker_row     <= IW'(2);
      walker_col     <= '0;
      walker_heading <= HEAD_EAST;
    end else begin
      state          <= state_next;
      try_k          <= try_k_next;
      walker_row     <= walker_row_next;
      walker_col     <= walker_col_next;
      walker_heading <= walker_heading_next;
    end
  end

  always_ff @(posedge clk) begin
    cand <= cand_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_row     <= 4'd2;
      start_col     <= 4'd0;
      start_heading <= HEAD_EAST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START_ROW:     start_row     <= cfg_data;
        CFG_START_COL:     start_col     <= cfg_data;
        CFG_START_HEADING: start_heading <= cfg_data[1:0];
        default:           start_row     <= start_row;
      endcase
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> (state == S_IDLE) && !ram_busy)
    else $error("transaction taken while walker busy");

  a_push_space: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_full)
    else $error("result pushed into full queue");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (try_k != 2'd3))
    else $error("probe index out of range");

  a_turn_around: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && try_k == 2'd2 && wall)
      |=> (walker_heading == 2'($past(walker_heading) + 2'd2)) && (state == S_IDLE))
    else $error("dead end did not reverse heading");

endmodule

/* hdl/maze_wall_follower_step.sv */
// top level of the right-hand maze wall follower
//
// channel  dir  handshake                    payload
// cfg      in   cfg_valid / cfg_ready        cfg_index, cfg_data
// s_axis   in   s_axis_tvalid / tready       tuser opcode, tdata cell fields
// m_axis   out  m_axis_tvalid / tready       tuser status, tdata position
//
// load, restart and edge steps are answered without a probe; a step that probes makes
// one wall store read per tried direction
// after reset the wall store is cleared, with s_axis_tready low until the clearing is done;
// configuration writes are taken throughout
// a two-entry result queue lets new transactions in while results wait
module maze_wall_follower_step #(
  parameter int MAZE_SIZE = mwf_pkg::MAZE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // cell_row[3:0], cell_col[7:4], cell_wall[8], zero
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // pos_row[3:0], pos_col[7:4], heading[9:8], zero
  output logic [1:0]  m_axis_tuser   // status[1:0]
);
  import mwf_pkg::*;

  localparam int IW = $clog2(MAZE_SIZE);
  localparam int AW = $clog2(MAZE_SIZE * MAZE_SIZE);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;
  logic          ram_busy;
  logic          fifo_full;
  logic          push;
  result_t       push_data;
  result_t       head;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {6'd0, head.heading, head.pos_col, head.pos_row};
  assign m_axis_tuser = head.status;

  mwf_maze_ram #(
    .MAZE_SIZE (MAZE_SIZE),
    .AW        (AW)
  ) u_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata),
    .busy  (ram_busy)
  );

  mwf_walker #(
    .MAZE_SIZE (MAZE_SIZE),
    .IW        (IW),
    .AW        (AW)
  ) u_walker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .opcode        (s_axis_tuser),
    .cell_row      (s_axis_tdata[3:0]),
    .cell_col      (s_axis_tdata[7:4]),
    .cell_wall     (s_axis_tdata[8]),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .ram_busy      (ram_busy),
    .fifo_full     (fifo_full),
    .push          (push),
    .push_data     (push_data)
  );

  mwf_out_fifo u_fifo (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .push_data     (push_data),
    .full          (fifo_full),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .head          (head)
  );

endmodule

/* verif/testbench.sv */
// testbench for the right-hand maze wall follower: directed edge cases, random walks, back-pressure
`timescale 1ns / 1ps

module testbench;
  import mwf_pkg::*;

  localparam int GRID = MAZE_SIZE_DEF;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int END_WAIT = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // cell_row[3:0], cell_col[7:4], cell_wall[8], zero
  logic [1:0] s_axis_tuser = '0;   // opcode[1:0]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // pos_row[3:0], pos_col[7:4], heading[9:8], zero
  logic [1:0] m_axis_tuser;        // status[1:0]

  maze_wall_follower_step dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #2 clk = ~clk;

  bit wall_map [GRID][GRID];
  logic [3:0] walk_row = 4'd2;
  logic [3:0] walk_col = 4'd0;
  logic [1:0] walk_head = HEAD_EAST;
  logic [3:0] start_row_cfg = 4'd2;
  logic [3:0] start_col_cfg = 4'd0;
  logic [1:0] start_head_cfg = HEAD_EAST;

  result_t expected_results[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int cycles = 0;
  int failures = 0;
  int items_sent = 0;
  int results_seen = 0;
  int exits_seen = 0;
  int noexit_seen = 0;
  int moves_seen = 0;

  function automatic bit blocked(int r, int c);
    if (r < 0 || c < 0 || r >= GRID || c >= GRID) return 1'b1;
    return wall_map[r][c];
  endfunction

  function automatic result_t follower_predict(logic [1:0] op, logic [3:0] r, logic [3:0] c,
                                               logic w);
    result_t res;
    logic [1:0] h;
    int nr;
    int nc;
    bit moved;
    res.status = STAT_DONE;
    case (op)
      OP_LOAD: wall_map[r][c] = w;
      OP_RESTART: begin
        walk_row = start_row_cfg;
        walk_col = start_col_cfg;
        walk_head = start_head_cfg;
      end
      OP_STEP: begin
        if (walk_col == GRID - 1 || walk_row == GRID - 1 || walk_row == 0) begin
          res.status = STAT_EXIT;
        end else if (walk_col == 0 && walk_head == HEAD_WEST) begin
          res.status = STAT_NOEXIT;
        end else begin
          res.status = STAT_MOVED;
          moved = 1'b0;
          // right, straight, left
          for (int k = 0; k < 3 && !moved; k++) begin
            h = walk_head + ((k == 0) ? 2'd1 : (k == 1) ? 2'd0 : 2'd3);
            nr = int'(walk_row);
            nc = int'(walk_col);
            case (h)
              HEAD_EAST:  nc = nc + 1;
              HEAD_SOUTH: nr = nr + 1;
              HEAD_WEST:  nc = nc - 1;
              default:    nr = nr - 1;
            endcase
            if (!blocked(nr, nc)) begin
              walk_row = 4'(nr);
              walk_col = 4'(nc);
              walk_head = h;
              moved = 1'b1;
            end
          end
          // dead end: turn around in place
          if (!moved) walk_head = walk_head + 2'd2;
        end
      end
      default: ;
    endcase
    res.pos_row = walk_row;
    res.pos_col = walk_col;
    res.heading = walk_head;
    return res;
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // result checking and prediction of each accepted transaction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.pos_row = m_axis_tdata[3:0];
      got.pos_col = m_axis_tdata[7:4];
      got.heading = m_axis_tdata[9:8];
      got.status = m_axis_tuser;
      results_seen++;
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
      end else begin
        want = expected_results.pop_front();
        compare_field("pos_row", int'(want.pos_row), int'(got.pos_row));
        compare_field("pos_col", int'(want.pos_col), int'(got.pos_col));
        compare_field("heading", int'(want.heading), int'(got.heading));
        compare_field("status", int'(want.status), int'(got.status));
        case (want.status)
          STAT_EXIT:   exits_seen++;
          STAT_NOEXIT: noexit_seen++;
          STAT_MOVED:  moves_seen++;
          default: ;
        endcase
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(follower_predict(s_axis_tuser, s_axis_tdata[3:0],
                                                  s_axis_tdata[7:4], s_axis_tdata[8]));
      items_sent++;
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic [3:0] r, logic [3:0] c, logic w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, w, c, r};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_START_ROW:     start_row_cfg = val;
      CFG_START_COL:     start_col_cfg = val;
      CFG_START_HEADING: start_head_cfg = val[1:0];
      default: ;
    endcase
  endtask

  task automatic set_start(logic [3:0] row, logic [3:0] col, logic [1:0] head);
    drain();
    write_reg(CFG_START_ROW, row);
    write_reg(CFG_START_COL, col);
    write_reg(CFG_START_HEADING, {2'b00, head});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_cell_loads();
    send_item(OP_LOAD, 4'd0, 4'd0, 1'b1);
    send_item(OP_LOAD, 4'd15, 4'd15, 1'b1);
    send_item(OP_LOAD, 4'd0, 4'd15, 1'b0);
    send_item(OP_LOAD, 4'd15, 4'd0, 1'b1);
    send_item(OP_LOAD, 4'd15, 4'd15, 1'b0);
    send_item(OP_NOP, 4'd15, 4'd15, 1'b1);
    send_item(OP_STEP, 4'd0, 4'd0, 1'b0);
  endtask

  task automatic test_edge_exits();
    drain();
    write_reg(CFG_UNUSED, 4'hf);
    cfg_valid <= 1'b0;
    set_start(4'd0, 4'd5, HEAD_NORTH);
    send_item(OP_RESTART, 4'd0, 4'd0, 1'b0);
    send_item(OP_STEP, 4'd0, 4'd0, 1'b0);
    set_start(4'd15, 4'd9, HEAD_SOUTH);
    send_item(OP_RESTART, 4'd0, 4'd0, 1'b0);
    send_item(OP_STEP, 4'd0, 4'd0, 1'b0);
    set_start(4'd8, 4'd15, HEAD_EAST);
    send_item(OP_RESTART, 4'd0, 4'd0, 1'b0);
    send_item(OP_STEP, 4'd0, 4'd0, 1'b0);
    set_start(4'd5, 4'd0, HEAD_WEST);
    send_item(OP_RESTART, 4'd0, 4'd0, 1'b0);
    send_item(OP_STEP, 4'd0, 4'd0, 1'b0);
  endtask

  task automatic test_dead_ends();
    // boxed in on three sides
    send_item(OP_LOAD, 4'd6, 4'd7, 1'b1);
    send_item(OP_LOAD, 4'd8, 4'd7, 1'b1);
    send_item(OP_LOAD, 4'd7, 4'd8, 1'b1);
    set_start(4'd7, 4'd7, HEAD_EAST);
    send_item(OP_RESTART, 4'd0, 4'd0, 1'b0);
    send_item(OP_STEP, 4'd0, 4'd0, 1'b0);
    send_item(OP_STEP, 4'd0, 4'd0, 1'b0);
    // left neighbour lies outside the grid
    send_item(OP_LOAD, 4'd4, 4'd0, 1'b1);
    send_item(OP_LOAD, 4'd5, 4'd1, 1'b1);
    set_start(4'd5, 4'd0, HEAD_NORTH);
    send_item(OP_RESTART, 4'd0, 4'd0, 1'b0);
    send_item(OP_STEP, 4'd0, 4'd0, 1'b0);
  endtask

  task automatic test_random_walks(int n_items);
    int sent;
    int roll;
    sent = 0;
    while (sent < n_items) begin
      repeat ($urandom_range(16, 4)) begin
        send_item(OP_LOAD, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  $urandom_range(99) < 40);
        sent++;
      end
      send_item(OP_RESTART, 4'($urandom_range(15)), 4'($urandom_range(15)),
                1'($urandom_range(1)));
      sent++;
      repeat ($urandom_range(30, 5)) begin
        roll = $urandom_range(99);
        if (roll < 90)
          send_item(OP_STEP, 4'($urandom_range(15)), 4'($urandom_range(15)),
                    1'($urandom_range(1)));
        else if (roll < 94)
          send_item(OP_NOP, 4'($urandom_range(15)), 4'($urandom_range(15)),
                    1'($urandom_range(1)));
        else if (roll < 97)
          send_item(OP_RESTART, 4'($urandom_range(15)), 4'($urandom_range(15)),
                    1'($urandom_range(1)));
        else
          send_item(OP_LOAD, 4'($urandom_range(15)), 4'($urandom_range(15)),
                    1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    send_item(OP_RESTART, 4'd0, 4'd0, 1'b0);
    test_random_walks(40);
    drain();
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 25;
    recv_stall_pct = 25;
    test_random_walks(20);
    drain();
    test_random_walks(20);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_cell_loads();
    test_edge_exits();
    test_dead_ends();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      repeat (2) begin
        set_start(4'($urandom_range(14, 1)), 4'($urandom_range(14)), 2'($urandom_range(3)));
        test_random_walks(150);
      end
    end
    test_backpressure();
    test_sender_pause();
    drain();
    repeat (END_WAIT) @(posedge clk);
    if (expected_results.size() != 0) begin
      failures++;
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
    end
    $display("covered %0d transactions in, %0d results checked: %0d moves or turns,",
             items_sent, results_seen, moves_seen);
    $display("%0d exits found, %0d no-exit reports, under four idling mixes and a long stall",
             exits_seen, noexit_seen);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
